>>> rtl/core/aes_cbc_pkg.sv
// ----------------------------------------------------------------------------
// AES-CBC package
// Payload types, S-box tables and the AES round and key-schedule functions.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_cbc_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_KEY_SIZE  = 3'd0;
  localparam logic [2:0] REG_KEY_WORD0 = 3'd1;
  localparam logic [2:0] REG_KEY_WORD1 = 3'd2;
  localparam logic [2:0] REG_KEY_WORD2 = 3'd3;
  localparam logic [2:0] REG_KEY_WORD3 = 3'd4;
  localparam logic [2:0] REG_IV_HIGH   = 3'd5;
  localparam logic [2:0] REG_IV_LOW    = 3'd6;
  localparam logic [2:0] REG_DIRECTION = 3'd7;

  // Key size codes
  localparam logic [1:0] KEY_128 = 2'd0;
  localparam logic [1:0] KEY_192 = 2'd1;
  localparam logic [1:0] KEY_256 = 2'd2;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        first_block;
  } in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_t;

  // Byte k of the block (big-endian) sits at index 15-k
  typedef logic [15:0][7:0]  state_t;
  // Round keys 0..14, 128 bits each
  typedef logic [14:0][127:0] rk_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic state_t sub_bytes(input state_t s, input logic inv);
    state_t t;
    for (int k = 0; k < 16; k++) begin
      t[k] = inv ? INV_SBOX[s[k]] : SBOX[s[k]];
    end
    return t;
  endfunction

  function automatic state_t shift_rows(input state_t s);
    state_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[15 - (c*4 + r)] = s[15 - ((((c + r) & 3) * 4) + r)];
      end
    end
    return t;
  endfunction

  function automatic state_t inv_shift_rows(input state_t s);
    state_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[15 - ((((c + r) & 3) * 4) + r)] = s[15 - (c*4 + r)];
      end
    end
    return t;
  endfunction

  function automatic state_t mix_columns(input state_t s);
    state_t t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[15 - 4*c];
      a1 = s[14 - 4*c];
      a2 = s[13 - 4*c];
      a3 = s[12 - 4*c];
      t[15 - 4*c] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[14 - 4*c] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[13 - 4*c] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[12 - 4*c] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return t;
  endfunction

  // Multiply by 9, 11, 13, 14 built from doublings
  function automatic logic [31:0] mul_9_11_13_14(input logic [7:0] a);
    logic [7:0] x2, x4, x8;
    x2 = xtime(a);
    x4 = xtime(x2);
    x8 = xtime(x4);
    return {x8 ^ a, x8 ^ x2 ^ a, x8 ^ x4 ^ a, x8 ^ x4 ^ x2};
  endfunction

  function automatic state_t inv_mix_columns(input state_t s);
    state_t t;
    logic [31:0] m0, m1, m2, m3;
    for (int c = 0; c < 4; c++) begin
      // fields: [31:24] x9, [23:16] x11, [15:8] x13, [7:0] x14
      m0 = mul_9_11_13_14(s[15 - 4*c]);
      m1 = mul_9_11_13_14(s[14 - 4*c]);
      m2 = mul_9_11_13_14(s[13 - 4*c]);
      m3 = mul_9_11_13_14(s[12 - 4*c]);
      t[15 - 4*c] = m0[7:0]   ^ m1[23:16] ^ m2[15:8]  ^ m3[31:24];
      t[14 - 4*c] = m0[31:24] ^ m1[7:0]   ^ m2[23:16] ^ m3[15:8];
      t[13 - 4*c] = m0[15:8]  ^ m1[31:24] ^ m2[7:0]   ^ m3[23:16];
      t[12 - 4*c] = m0[23:16] ^ m1[15:8]  ^ m2[31:24] ^ m3[7:0];
    end
    return t;
  endfunction

  // Key schedule; unused tail words only feed rounds past the last one
  function automatic rk_t expand_key(input logic [255:0] key, input logic [1:0] ks);
    logic [59:0][31:0] w;
    logic [31:0] t;
    logic [7:0]  rc;
    int          nk;
    int          j;
    rk_t         rk;
    nk = (ks == KEY_128) ? 4 : ((ks == KEY_192) ? 6 : 8);
    rc = 8'h01;
    j  = 0;
    for (int i = 0; i < 60; i++) begin
      if (i < nk) begin
        w[i] = key[255 - 32*i -: 32];
      end else begin
        t = w[i-1];
        if (j == 0) begin
          t  = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
          rc = xtime(rc);
        end else if (nk == 8 && j == 4) begin
          t = sub_word(t);
        end
        w[i] = w[i-nk] ^ t;
      end
      j = (j + 1 == nk) ? 0 : j + 1;
    end
    for (int r = 0; r < 15; r++) begin
      rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    end
    return rk;
  endfunction

  function automatic state_t aes_encrypt(input state_t pt, input rk_t rk,
                                         input logic [3:0] nr);
    state_t s;
    state_t t;
    s = pt ^ rk[0];
    for (int r = 1; r < 14; r++) begin
      t = mix_columns(shift_rows(sub_bytes(s, 1'b0))) ^ rk[r];
      if (r < nr) s = t;
    end
    return shift_rows(sub_bytes(s, 1'b0)) ^ rk[nr];
  endfunction

  function automatic state_t aes_decrypt(input state_t ct, input rk_t rk,
                                         input logic [3:0] nr);
    state_t s;
    state_t t;
    s = ct ^ rk[nr];
    for (int r = 13; r >= 1; r--) begin
      t = inv_mix_columns(sub_bytes(inv_shift_rows(s), 1'b1) ^ rk[r]);
      if (r < nr) s = t;
    end
    return sub_bytes(inv_shift_rows(s), 1'b1) ^ rk[0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/aes_cbc_cipher.sv
// ----------------------------------------------------------------------------
// AES-CBC cipher
// CBC-mode AES encrypt/decrypt with 128/192/256-bit key, one block per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries one 128-bit block per item
//   plus a first_block flag that restarts the chain from the IV registers.
//   Output channel out_valid/out_stall/out_data carries the result block.
//   Configuration (key size, key words, IV, direction) is written through
//   cfg_we/cfg_index/cfg_data while no item is in flight; the round keys are
//   rebuilt in the cycle after each write, and in_stall is high for that one
//   cycle so no item sees stale round keys.
//   out_valid rises in the cycle after acceptance. Throughput: one item per
//   cycle unless the receiver or a key rebuild stalls the input; the full round
//   chain sits between the chain register and the result register, so each
//   block sees the previous ciphertext at once. The result register doubles
//   as the output stage: a new item is taken whenever it is empty or being
//   drained the same cycle and keys are current. A held result holds under a
//   receiver stall. Reset clears the config registers, chain and out_valid.
`default_nettype none

module aes_cbc_cipher (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire aes_cbc_pkg::in_t                   in_data,
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      aes_cbc_pkg::out_t                  out_data,
  input  wire logic                               cfg_we,
  input  wire logic [aes_cbc_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [aes_cbc_pkg::CfgDataW-1:0]   cfg_data
);

  logic [1:0]          key_size;
  logic [3:0][63:0]    key_words;
  logic [127:0]        iv;
  logic                direction;
  logic [127:0]        chain;
  aes_cbc_pkg::rk_t    round_keys;
  logic                rk_stale;

  logic                in_accept;
  logic [3:0]          num_rounds;
  logic [127:0]        blk;
  logic [127:0]        prev;
  logic [127:0]        enc_res;
  logic [127:0]        dec_res;
  logic [127:0]        res_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_size  <= 2'd0;
      key_words <= '0;
      iv        <= '0;
      direction <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        aes_cbc_pkg::REG_KEY_SIZE:  key_size     <= cfg_data[1:0];
        aes_cbc_pkg::REG_KEY_WORD0: key_words[3] <= cfg_data;
        aes_cbc_pkg::REG_KEY_WORD1: key_words[2] <= cfg_data;
        aes_cbc_pkg::REG_KEY_WORD2: key_words[1] <= cfg_data;
        aes_cbc_pkg::REG_KEY_WORD3: key_words[0] <= cfg_data;
        aes_cbc_pkg::REG_IV_HIGH:   iv[127:64]   <= cfg_data;
        aes_cbc_pkg::REG_IV_LOW:    iv[63:0]     <= cfg_data;
        aes_cbc_pkg::REG_DIRECTION: direction    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Round key store, rebuilt from the key registers
  always_ff @(posedge clk) begin
    round_keys <= aes_cbc_pkg::expand_key(key_words, key_size);
  end

  // Round keys are rebuilt in the cycle after a register write; hold the input meanwhile
  always_ff @(posedge clk) begin
    if (rst) begin
      rk_stale <= 1'b0;
    end else begin
      rk_stale <= cfg_we;
    end
  end

  // Cipher datapath
  assign num_rounds = (key_size == aes_cbc_pkg::KEY_128) ? 4'd10 :
                      ((key_size == aes_cbc_pkg::KEY_192) ? 4'd12 : 4'd14);
  assign blk        = {in_data.block_high, in_data.block_low};
  assign prev       = in_data.first_block ? iv : chain;
  assign enc_res    = aes_cbc_pkg::aes_encrypt(blk ^ prev, round_keys, num_rounds);
  assign dec_res    = aes_cbc_pkg::aes_decrypt(blk, round_keys, num_rounds) ^ prev;
  assign res_next   = direction ? dec_res : enc_res;

  // Handshake: result register is also the output stage
  assign in_stall  = (out_valid & out_stall) | rk_stale;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      chain     <= '0;
    end else begin
      if (in_accept) begin
        out_valid <= 1'b1;
        chain     <= direction ? blk : enc_res;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data.result_high <= res_next[127:64];
      out_data.result_low  <= res_next[63:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/aes_cbc_checker.sv
// ----------------------------------------------------------------------------
// AES-CBC port checker
// Concurrent checks on the cipher's ports, bound into the cipher module.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_cbc_assert (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire aes_cbc_pkg::out_t out_data,
  input wire logic              cfg_we
);

  // Nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

  // An accepted item shows up in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result");

  // Input is never stalled while the output stage is free and keys are current
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && out_stall) && !$past(cfg_we) |-> !in_stall)
    else $error("input stalled with output free");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind aes_cbc_cipher aes_cbc_assert u_aes_cbc_assert (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_we    (cfg_we)
);

`default_nettype wire

>>> verif/aes_cbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-CBC checker
// Watches the configuration port and both item channels. It keeps its own copy
// of the key, IV, direction and chain. It computes the expected block for each
// accepted input item and compares each accepted output item with the oldest
// expected block.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_cbc_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  input  wire logic                             in_stall,
  input  wire aes_cbc_pkg::in_t                 in_data,
  input  wire logic                             out_valid,
  input  wire logic                             out_stall,
  input  wire aes_cbc_pkg::out_t                out_data,
  input  wire logic                             cfg_we,
  input  wire logic [aes_cbc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [aes_cbc_pkg::CfgDataW-1:0] cfg_data,
  output int                                    failures,
  output int                                    pending
);

  // shadow configuration and chain
  logic [1:0]   key_size;
  logic [255:0] cipher_key;
  logic [127:0] init_vec;
  logic [127:0] chain;
  logic         decrypt;

  logic [7:0]        fwd_sub [256];
  logic [7:0]        inv_sub [256];
  aes_cbc_pkg::out_t expected_blocks [$];

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  // S-boxes built from the field inverse and the affine map
  initial begin
    logic [7:0] v;
    for (int x = 0; x < 256; x++) begin
      v = 8'h00;
      for (int y = 1; y < 256; y++) begin
        if (gf_mul(x[7:0], y[7:0]) == 8'h01) v = y[7:0];
      end
      fwd_sub[x] = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
                   ^ {v[3:0], v[7:4]} ^ 8'h63;
    end
    for (int x = 0; x < 256; x++) inv_sub[fwd_sub[x]] = x[7:0];
  end

  function automatic logic [31:0] sub_w32(input logic [31:0] w);
    return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
  endfunction

  // byte k of a block sits at bits 127-8k down
  function automatic logic [127:0] sub_state(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int k = 0; k < 16; k++) begin
      t[127-8*k -: 8] = inv ? inv_sub[s[127-8*k -: 8]] : fwd_sub[s[127-8*k -: 8]];
    end
    return t;
  endfunction

  function automatic logic [127:0] rotate_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) t[127-8*(4*((c+r)%4)+r) -: 8] = s[127-8*(4*c+r) -: 8];
        else     t[127-8*(4*c+r) -: 8] = s[127-8*(4*((c+r)%4)+r) -: 8];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_state(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0]   a [4];
    logic [7:0]   m [4];
    if (inv) begin
      m = '{8'd14, 8'd11, 8'd13, 8'd9};
    end else begin
      m = '{8'd2, 8'd3, 8'd1, 8'd1};
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) a[r] = s[127-8*(4*c+r) -: 8];
      // circulant matrix: row r uses coefficient m[(j-r)&3] for byte j
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = gf_mul(a[0], m[(4-r)%4]) ^ gf_mul(a[1], m[(5-r)%4])
                                ^ gf_mul(a[2], m[(6-r)%4]) ^ gf_mul(a[3], m[(7-r)%4]);
      end
    end
    return t;
  endfunction

  // one AES block with the current shadow key; key size 3 acts as 256 bits
  function automatic logic [127:0] aes_block(input logic [127:0] din, input logic inv);
    logic [31:0]  w [60];
    logic [127:0] rk [15];
    logic [127:0] s;
    logic [31:0]  t;
    logic [7:0]   rc;
    int           nk;
    int           nr;
    nk = (key_size == aes_cbc_pkg::KEY_128) ? 4 :
         ((key_size == aes_cbc_pkg::KEY_192) ? 6 : 8);
    nr = nk + 6;
    rc = 8'h01;
    for (int i = 0; i < 4*(nr+1); i++) begin
      if (i < nk) begin
        w[i] = cipher_key[255-32*i -: 32];
      end else begin
        t = w[i-1];
        if (i % nk == 0) begin
          t  = sub_w32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
          rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
        end else if (nk == 8 && i % nk == 4) begin
          t = sub_w32(t);
        end
        w[i] = w[i-nk] ^ t;
      end
    end
    for (int r = 0; r <= nr; r++) rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    if (!inv) begin
      s = din ^ rk[0];
      for (int r = 1; r < nr; r++) begin
        s = mix_state(rotate_rows(sub_state(s, 1'b0), 1'b0), 1'b0) ^ rk[r];
      end
      s = rotate_rows(sub_state(s, 1'b0), 1'b0) ^ rk[nr];
    end else begin
      s = din ^ rk[nr];
      for (int r = nr - 1; r >= 1; r--) begin
        s = mix_state(sub_state(rotate_rows(s, 1'b1), 1'b1) ^ rk[r], 1'b1);
      end
      s = sub_state(rotate_rows(s, 1'b1), 1'b1) ^ rk[0];
    end
    return s;
  endfunction

  always @(posedge clk) begin
    logic [127:0]      prev;
    logic [127:0]      blk;
    logic [127:0]      res;
    aes_cbc_pkg::out_t want;
    if (rst) begin
      key_size   <= 2'd0;
      cipher_key <= '0;
      init_vec   <= '0;
      chain      <= '0;
      decrypt    <= 1'b0;
      failures   <= 0;
      pending    <= 0;
      expected_blocks.delete();
    end else begin
      // output side: compare with oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected output item %h", $time, out_data);
          failures <= failures + 1;
        end else begin
          want = expected_blocks.pop_front();
          if (out_data !== want) begin
            $display("%0t: result expected %h actual %h", $time, want, out_data);
            failures <= failures + 1;
          end
        end
      end
      // input side: CBC step
      if (in_valid && !in_stall) begin
        blk  = {in_data.block_high, in_data.block_low};
        prev = in_data.first_block ? init_vec : chain;
        if (!decrypt) begin
          res   = aes_block(blk ^ prev, 1'b0);
          chain <= res;
        end else begin
          res   = aes_block(blk, 1'b1) ^ prev;
          chain <= blk;
        end
        expected_blocks.push_back('{result_high: res[127:64], result_low: res[63:0]});
      end
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          aes_cbc_pkg::REG_KEY_SIZE:  key_size <= cfg_data[1:0];
          aes_cbc_pkg::REG_KEY_WORD0: cipher_key[255:192] <= cfg_data;
          aes_cbc_pkg::REG_KEY_WORD1: cipher_key[191:128] <= cfg_data;
          aes_cbc_pkg::REG_KEY_WORD2: cipher_key[127:64] <= cfg_data;
          aes_cbc_pkg::REG_KEY_WORD3: cipher_key[63:0] <= cfg_data;
          aes_cbc_pkg::REG_IV_HIGH:   init_vec[127:64] <= cfg_data;
          aes_cbc_pkg::REG_IV_LOW:    init_vec[63:0] <= cfg_data;
          aes_cbc_pkg::REG_DIRECTION: decrypt <= cfg_data[0];
          default: ;
        endcase
      end
      pending <= expected_blocks.size();
    end
  end

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-CBC cipher testbench
// Drives directed and random CBC chains under several key sizes, keys, IVs and
// both directions. Both sides idle and stall at random. A separate checker
// predicts and compares every output item.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  logic                             clk;
  logic                             rst;
  logic                             in_valid;
  logic                             in_stall;
  aes_cbc_pkg::in_t                 in_data;
  logic                             out_valid;
  logic                             out_stall;
  aes_cbc_pkg::out_t                out_data;
  logic                             cfg_we;
  logic [aes_cbc_pkg::CfgIdxW-1:0]  cfg_index;
  logic [aes_cbc_pkg::CfgDataW-1:0] cfg_data;
  int                               failures;
  int                               pending;
  logic                             calm;

  aes_cbc_cipher dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  aes_cbc_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver stalls about 18 percent of cycles, except in calm stretches
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 18);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                            input logic first);
    if (!calm) begin
      while ($urandom_range(99) < 18) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_data  <= '{block_high: hi, block_low: lo, first_block: first};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and wait until every expected block has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [aes_cbc_pkg::CfgIdxW-1:0] idx,
                           input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_setup(input logic [1:0] ks, input logic [255:0] key,
                            input logic [127:0] iv, input logic dir);
    write_reg(aes_cbc_pkg::REG_KEY_SIZE, {62'd0, ks});
    write_reg(aes_cbc_pkg::REG_KEY_WORD0, key[255:192]);
    write_reg(aes_cbc_pkg::REG_KEY_WORD1, key[191:128]);
    write_reg(aes_cbc_pkg::REG_KEY_WORD2, key[127:64]);
    write_reg(aes_cbc_pkg::REG_KEY_WORD3, key[63:0]);
    write_reg(aes_cbc_pkg::REG_IV_HIGH, iv[127:64]);
    write_reg(aes_cbc_pkg::REG_IV_LOW, iv[63:0]);
    write_reg(aes_cbc_pkg::REG_DIRECTION, {63'd0, dir});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [255:0] key;
    logic [127:0] iv;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    calm      = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setup: chain starts at zero before any first block
    send_block('0, '0, 1'b0);
    send_block('1, '1, 1'b0);
    send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b1);
    drain();

    // all-ones key and IV, 128-bit encrypt
    load_setup(aes_cbc_pkg::KEY_128, '1, '1, 1'b0);
    send_block('1, '1, 1'b1);
    send_block('0, '0, 1'b0);
    send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    send_block('0, '1, 1'b1);
    drain();

    // key size three behaves as 256 bits, decrypt
    load_setup(2'd3, {rand64(), rand64(), rand64(), rand64()}, {rand64(), rand64()}, 1'b1);
    send_block('0, '0, 1'b1);
    send_block('1, '1, 1'b0);
    send_block(rand64(), rand64(), 1'b0);
    send_block(rand64(), rand64(), 1'b1);
    drain();

    // 192-bit decrypt, then 256-bit encrypt; unused key words random
    load_setup(aes_cbc_pkg::KEY_192, {rand64(), rand64(), rand64(), rand64()}, '0, 1'b1);
    send_block('1, '0, 1'b1);
    send_block(rand64(), rand64(), 1'b0);
    send_block('0, '1, 1'b0);
    drain();
    load_setup(aes_cbc_pkg::KEY_256, '0, '1, 1'b0);
    send_block('0, '0, 1'b1);
    send_block('1, '1, 1'b0);
    send_block(rand64(), rand64(), 1'b0);
    drain();

    // random CBC chains across all key sizes and both directions
    for (int p = 0; p < 8; p++) begin
      key = (p == 1) ? '1 : ((p == 6) ? '0 : {rand64(), rand64(), rand64(), rand64()});
      iv  = (p == 5) ? '1 : {rand64(), rand64()};
      load_setup(p[1:0], key, iv, p[2]);
      calm = (p == 3);
      for (int n = 0; n < 200; n++) begin
        send_block(rand64(), rand64(), (n == 0) || ($urandom_range(15) == 0));
      end
      drain();
      calm = 1'b0;
    end

    repeat (5) @(posedge clk);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
